@@ hw/rtl/abr_pkg.sv @@
// ----------------------------------------------------------------------------
// abr_pkg
// shared constants, types and helper functions of the shape rasterizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package abr_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 32;
    localparam int COUNT_W    = 17;
    localparam int SC_W       = 19;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;
    localparam logic [COUNT_W-1:0]    COUNT_MAX = 17'h1FFFF;
    localparam logic [7:0]            ALPHA_MAX = 8'hFF;

    typedef enum logic [1:0]
    {
        KIND_READ  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_RECT  = 2'd2,
        KIND_DISC  = 2'd3
    } kind_t;

    typedef logic signed [SC_W-1:0] sc_t;

    typedef struct packed
    {
        logic clearing;
        logic idle;
        logic rd_valid;
    } frm_stat_t;

    // exact x / 255 for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

    // (d - 1)^2 from d^2
    function automatic logic [31:0] sq_step(input logic [31:0] sq, input sc_t d);
        logic signed [33:0] t;
        t = $signed({2'b00, sq}) - (34'(d) <<< 1) + 34'sd1;
        return t[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/abr_blend.sv @@
// ----------------------------------------------------------------------------
// abr_blend
// alpha blend of paint over background, one product stage then divide by 255
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abr_blend
(
    input  wire logic        clk,
    input  wire logic [31:0] fg,
    input  wire logic [31:0] bg,
    output logic      [31:0] mix
);

    logic        a0_reg;
    logic        a255_reg;
    logic [31:0] fg_reg;
    logic [31:0] bg_reg;
    logic [15:0] sum_reg [3];
    logic [15:0] sum_next [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = 16'(fg[7:0]) * 16'(fg[8*c+8 +: 8])
                        + 16'(abr_pkg::ALPHA_MAX - fg[7:0]) * 16'(bg[8*c+8 +: 8]);
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg   <= (fg[7:0] == 8'd0);
        a255_reg <= (fg[7:0] == abr_pkg::ALPHA_MAX);
        fg_reg   <= fg;
        bg_reg   <= bg;
        for (int c = 0; c < 3; c++)
        begin
            sum_reg[c] <= sum_next[c];
        end
    end

    always_comb
    begin
        if (a0_reg)
        begin
            mix = bg_reg;
        end
        else if (a255_reg)
        begin
            mix = {fg_reg[31:8], abr_pkg::ALPHA_MAX};
        end
        else
        begin
            mix = {abr_pkg::div255(sum_reg[2]), abr_pkg::div255(sum_reg[1]),
                   abr_pkg::div255(sum_reg[0]), abr_pkg::ALPHA_MAX};
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/abr_frame.sv @@
// ----------------------------------------------------------------------------
// abr_frame
// framebuffer memory with clearing pass and read-blend-write pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abr_frame
#(
    parameter int MAX_WIDTH  = abr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abr_pkg::DEF_MAX_HEIGHT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pix_valid,
    input  wire logic                          pix_write,
    input  wire logic [((MAX_WIDTH*MAX_HEIGHT > 1) ?
                        $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)-1:0] pix_addr,
    input  wire logic [31:0]                   pix_paint,
    output logic      [31:0]                   rd_word,
    output abr_pkg::frm_stat_t                 stat
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          s1_valid_reg;
    logic          s1_write_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [31:0]   s1_paint_reg;
    logic          s2_valid_reg;
    logic          s2_write_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [31:0]   blend_word;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    abr_blend u_blend
    (
        .clk (clk),
        .fg  (s1_paint_reg),
        .bg  (rd_data_reg),
        .mix (blend_word)
    );

    assign wr_en   = clr_busy_reg | (s2_valid_reg & s2_write_reg);
    assign wr_addr = clr_busy_reg ? clr_addr_reg : s2_addr_reg;
    assign wr_data = clr_busy_reg ? 32'd0 : blend_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pix_valid)
        begin
            rd_data_reg <= mem[pix_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            s1_valid_reg <= pix_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_write_reg <= pix_write;
        s1_addr_reg  <= pix_addr;
        s1_paint_reg <= pix_paint;
        s2_write_reg <= s1_write_reg;
        s2_addr_reg  <= s1_addr_reg;
    end

    assign rd_word       = rd_data_reg;
    assign stat.clearing = clr_busy_reg;
    assign stat.idle     = !clr_busy_reg && !s1_valid_reg && !s2_valid_reg;
    assign stat.rd_valid = s1_valid_reg && !s1_write_reg;

endmodule

`default_nettype wire

@@ hw/rtl/abr_scan.sv @@
// ----------------------------------------------------------------------------
// abr_scan
// command sequencer: clips the shape and walks its covered pixels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abr_scan
#(
    parameter int MAX_WIDTH  = abr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abr_pkg::DEF_MAX_HEIGHT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            kind,
    input  wire logic signed [abr_pkg::COORD_W-1:0]    pos_x,
    input  wire logic signed [abr_pkg::COORD_W-1:0]    pos_y,
    input  wire logic signed [abr_pkg::COORD_W-1:0]    extent_w,
    input  wire logic signed [abr_pkg::COORD_W-1:0]    extent_h,
    input  wire logic signed [abr_pkg::COORD_W-1:0]    radius,
    input  wire logic [abr_pkg::COLOR_W-1:0]           paint,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]        act_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]       act_h,
    input  wire abr_pkg::frm_stat_t                    stat,
    input  wire logic [31:0]                           rd_word,
    input  wire logic                                  out_free,
    output logic                                       pix_valid,
    output logic                                       pix_write,
    output logic [((MAX_WIDTH*MAX_HEIGHT > 1) ?
                   $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)-1:0] pix_addr,
    output logic [31:0]                                pix_paint,
    output logic                                       done,
    output logic [abr_pkg::COLOR_W-1:0]                res_color,
    output logic [abr_pkg::COUNT_W-1:0]                res_count
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_SET1  = 5'b00010,
        S_SET2  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DRAIN = 5'b10000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    abr_pkg::kind_t                kind_reg;
    abr_pkg::sc_t                  px_reg;
    abr_pkg::sc_t                  py_reg;
    abr_pkg::sc_t                  ew_reg;
    abr_pkg::sc_t                  eh_reg;
    abr_pkg::sc_t                  r_reg;
    logic [31:0]                   paint_reg;
    abr_pkg::sc_t                  x0_reg;
    abr_pkg::sc_t                  x1_reg;
    abr_pkg::sc_t                  y0_reg;
    abr_pkg::sc_t                  y1_reg;
    logic                          empty_reg;
    logic [31:0]                   rr_reg;
    logic [XW-1:0]                 x_reg;
    logic [YW-1:0]                 y_reg;
    logic [AW-1:0]                 row_base_reg;
    abr_pkg::sc_t                  dx0_reg;
    logic [31:0]                   dx0sq_reg;
    abr_pkg::sc_t                  dx_reg;
    logic [31:0]                   dxsq_reg;
    abr_pkg::sc_t                  dy_reg;
    logic [31:0]                   dysq_reg;
    logic [abr_pkg::COUNT_W-1:0]   count_reg;
    logic [31:0]                   color_reg;

    abr_pkg::sc_t                  aw_s;
    abr_pkg::sc_t                  ah_s;
    abr_pkg::sc_t                  xa;
    abr_pkg::sc_t                  xb;
    abr_pkg::sc_t                  ya;
    abr_pkg::sc_t                  yb;
    abr_pkg::sc_t                  x0_c;
    abr_pkg::sc_t                  x1_c;
    abr_pkg::sc_t                  y0_c;
    abr_pkg::sc_t                  y1_c;
    logic                          is_disc;
    logic                          empty_c;
    abr_pkg::sc_t                  dx0_c;
    abr_pkg::sc_t                  dy0_c;
    abr_pkg::sc_t                  dx0_abs;
    abr_pkg::sc_t                  dy0_abs;
    logic [31:0]                   dx0sq_c;
    logic [31:0]                   dy0sq_c;
    logic [32:0]                   dist_c;
    logic                          covered;
    logic                          last_col;
    logic                          last_row;
    logic                          accept;

    assign accept  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !stat.clearing;
    assign is_disc = (kind_reg == abr_pkg::KIND_DISC);
    assign aw_s    = abr_pkg::sc_t'(act_w);
    assign ah_s    = abr_pkg::sc_t'(act_h);

    // clip bounds, inclusive on both ends
    always_comb
    begin
        xa   = is_disc ? (px_reg - r_reg) : px_reg;
        xb   = is_disc ? (px_reg + r_reg) : (px_reg + ew_reg - abr_pkg::sc_t'(1));
        ya   = is_disc ? (py_reg - r_reg) : py_reg;
        yb   = is_disc ? (py_reg + r_reg) : (py_reg + eh_reg - abr_pkg::sc_t'(1));
        x0_c = (xa < 0) ? '0 : xa;
        y0_c = (ya < 0) ? '0 : ya;
        x1_c = (xb > aw_s - abr_pkg::sc_t'(1)) ? (aw_s - abr_pkg::sc_t'(1)) : xb;
        y1_c = (yb > ah_s - abr_pkg::sc_t'(1)) ? (ah_s - abr_pkg::sc_t'(1)) : yb;
        empty_c = (x0_c > x1_c) || (y0_c > y1_c)
               || (is_disc ? (r_reg <= 0) : ((ew_reg <= 0) || (eh_reg <= 0)));
    end

    always_comb
    begin
        dx0_c   = px_reg - x0_reg;
        dy0_c   = py_reg - y0_reg;
        dx0_abs = (dx0_c < 0) ? -dx0_c : dx0_c;
        dy0_abs = (dy0_c < 0) ? -dy0_c : dy0_c;
        dx0sq_c = 32'(dx0_abs[15:0]) * 32'(dx0_abs[15:0]);
        dy0sq_c = 32'(dy0_abs[15:0]) * 32'(dy0_abs[15:0]);
    end

    assign dist_c   = {1'b0, dxsq_reg} + {1'b0, dysq_reg};
    assign covered  = !is_disc || (dist_c <= {1'b0, rr_reg});
    assign last_col = (x_reg == x1_reg[XW-1:0]);
    assign last_row = (y_reg == y1_reg[YW-1:0]);

    assign pix_valid = (state_reg == S_SCAN) && covered;
    assign pix_write = (kind_reg != abr_pkg::KIND_READ);
    assign pix_addr  = row_base_reg + AW'(x_reg);
    assign pix_paint = paint_reg;

    assign done      = (state_reg == S_DRAIN) && stat.idle && out_free;
    assign res_color = color_reg;
    assign res_count = count_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SET1;
                end
            end
            S_SET1:
            begin
                state_next = S_SET2;
            end
            S_SET2:
            begin
                state_next = empty_reg ? S_DRAIN : S_SCAN;
            end
            S_SCAN:
            begin
                if (last_col && last_row)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            color_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                count_reg <= '0;
                color_reg <= '0;
            end
            else
            begin
                if (pix_valid && pix_write && (count_reg != abr_pkg::COUNT_MAX))
                begin
                    count_reg <= count_reg + abr_pkg::COUNT_W'(1);
                end
                if (stat.rd_valid)
                begin
                    color_reg <= rd_word;
                end
            end
        end
    end

    // command capture; a read or single pixel walks as a 1 by 1 rectangle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= abr_pkg::kind_t'(kind);
            px_reg    <= abr_pkg::sc_t'(pos_x);
            py_reg    <= abr_pkg::sc_t'(pos_y);
            r_reg     <= abr_pkg::sc_t'(radius);
            paint_reg <= paint;
            if ((kind == abr_pkg::KIND_READ) || (kind == abr_pkg::KIND_PIXEL))
            begin
                ew_reg <= abr_pkg::sc_t'(1);
                eh_reg <= abr_pkg::sc_t'(1);
            end
            else
            begin
                ew_reg <= abr_pkg::sc_t'(extent_w);
                eh_reg <= abr_pkg::sc_t'(extent_h);
            end
        end
        if (state_reg == S_SET1)
        begin
            x0_reg    <= x0_c;
            x1_reg    <= x1_c;
            y0_reg    <= y0_c;
            y1_reg    <= y1_c;
            empty_reg <= empty_c;
            rr_reg    <= 32'(r_reg[14:0]) * 32'(r_reg[14:0]);
        end
        if (state_reg == S_SET2)
        begin
            x_reg        <= x0_reg[XW-1:0];
            y_reg        <= y0_reg[YW-1:0];
            row_base_reg <= AW'(y0_reg[YW-1:0]) * AW'(act_w);
            dx0_reg      <= dx0_c;
            dx0sq_reg    <= dx0sq_c;
            dx_reg       <= dx0_c;
            dxsq_reg     <= dx0sq_c;
            dy_reg       <= dy0_c;
            dysq_reg     <= dy0sq_c;
        end
        if (state_reg == S_SCAN)
        begin
            if (last_col)
            begin
                x_reg        <= x0_reg[XW-1:0];
                dx_reg       <= dx0_reg;
                dxsq_reg     <= dx0sq_reg;
                y_reg        <= y_reg + YW'(1);
                dy_reg       <= dy_reg - abr_pkg::sc_t'(1);
                dysq_reg     <= abr_pkg::sq_step(dysq_reg, dy_reg);
                row_base_reg <= row_base_reg + AW'(act_w);
            end
            else
            begin
                x_reg    <= x_reg + XW'(1);
                dx_reg   <= dx_reg - abr_pkg::sc_t'(1);
                dxsq_reg <= abr_pkg::sq_step(dxsq_reg, dx_reg);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/alpha_blend_shape_rasterizer.sv @@
// ----------------------------------------------------------------------------
// alpha_blend_shape_rasterizer
// alpha blended pixel, rectangle and disc fill over an RGBA framebuffer
//
//   port group  dir   transfer when          carries
//   in_*        in    in_valid & in_ready    kind, pos, extents, radius, paint
//   out_*       out   out_valid & out_ready  read_color, pixels_touched
//   cfg_*       in    cfg_valid & cfg_ready  cfg_index, cfg_data
//
// a command passes the setup states S_SET1 and S_SET2, then takes one cycle
// per pixel of its clipped bounding box (one read-modify-write per cycle on
// the frame memory's one read and one write port), skipping the scan when
// nothing is left after clipping, and waits in S_DRAIN until the pipeline is
// idle and the output register is free; the next command can enter in the
// cycle after the result is loaded; after reset a clearing pass writes zero
// to all MAX_WIDTH*MAX_HEIGHT words, and no command is taken meanwhile
// a stalled result waits in the output register while the next command runs
// up to its drain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alpha_blend_shape_rasterizer
#(
    parameter int MAX_WIDTH  = abr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = abr_pkg::DEF_MAX_HEIGHT
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          kind,
    input  wire logic signed [abr_pkg::COORD_W-1:0]  pos_x,
    input  wire logic signed [abr_pkg::COORD_W-1:0]  pos_y,
    input  wire logic signed [abr_pkg::COORD_W-1:0]  extent_w,
    input  wire logic signed [abr_pkg::COORD_W-1:0]  extent_h,
    input  wire logic signed [abr_pkg::COORD_W-1:0]  radius,
    input  wire logic [abr_pkg::COLOR_W-1:0]         paint,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [abr_pkg::COLOR_W-1:0]              read_color,
    output logic [abr_pkg::COUNT_W-1:0]              pixels_touched,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [abr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [abr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DWX   = $clog2(MAX_WIDTH + 1);
    localparam int DWY   = $clog2(MAX_HEIGHT + 1);

    logic [abr_pkg::CFG_DATA_W-1:0] image_width_reg;
    logic [abr_pkg::CFG_DATA_W-1:0] image_height_reg;
    logic [12:0]                    aw_full;
    logic [12:0]                    ah_full;
    logic [DWX-1:0]                 act_w;
    logic [DWY-1:0]                 act_h;
    abr_pkg::frm_stat_t             stat;
    logic [31:0]                    rd_word;
    logic                           pix_valid;
    logic                           pix_write;
    logic [AW-1:0]                  pix_addr;
    logic [31:0]                    pix_paint;
    logic                           done;
    logic [abr_pkg::COLOR_W-1:0]    res_color;
    logic [abr_pkg::COUNT_W-1:0]    res_count;
    logic                           out_valid_reg;
    logic [abr_pkg::COLOR_W-1:0]    read_color_reg;
    logic [abr_pkg::COUNT_W-1:0]    pixels_touched_reg;
    logic                           out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= abr_pkg::DIM_RESET;
            image_height_reg <= abr_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                abr_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                abr_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // dimensions above the build limits act as the limits
    assign aw_full = (13'(image_width_reg) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH)
                                                           : 13'(image_width_reg);
    assign ah_full = (13'(image_height_reg) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                             : 13'(image_height_reg);
    assign act_w   = aw_full[DWX-1:0];
    assign act_h   = ah_full[DWY-1:0];

    abr_scan
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .extent_w  (extent_w),
        .extent_h  (extent_h),
        .radius    (radius),
        .paint     (paint),
        .act_w     (act_w),
        .act_h     (act_h),
        .stat      (stat),
        .rd_word   (rd_word),
        .out_free  (out_free),
        .pix_valid (pix_valid),
        .pix_write (pix_write),
        .pix_addr  (pix_addr),
        .pix_paint (pix_paint),
        .done      (done),
        .res_color (res_color),
        .res_count (res_count)
    );

    abr_frame
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_write (pix_write),
        .pix_addr  (pix_addr),
        .pix_paint (pix_paint),
        .rd_word   (rd_word),
        .stat      (stat)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            read_color_reg     <= res_color;
            pixels_touched_reg <= res_count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_color     = read_color_reg;
    assign pixels_touched = pixels_touched_reg;

`ifndef SYNTH
    // a nonzero color only comes from a read, which touches nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_color != '0) |-> pixels_touched == '0)
        else $error("read result carries a touch count");

    // no command enters while the frame is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !in_ready)
        else $error("command taken during clearing pass");

    // a result is only loaded once all writes have landed
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> stat.idle && !pix_valid)
        else $error("result loaded with pipeline busy");

    // the memory pipeline never runs while idle for input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pix_valid)
        else $error("pixel issued while idle");
`endif

endmodule

`default_nettype wire

@@ verif/alpha_blend_shape_rasterizer_tb.sv @@
// ----------------------------------------------------------------------------
// alpha_blend_shape_rasterizer_tb
// self-checking bench for the alpha blended pixel, rectangle and disc filler
//
// a scoreboard keeps its own copy of the framebuffer and image size, blends
// every accepted command into it and compares each result word and touch
// count in order; directed corner commands come first, then random phases
// under several image sizes with random idling on both channels and one long
// result stall that backs the block up into its input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alpha_blend_shape_rasterizer_tb;

    localparam int FRAME_DEPTH = abr_pkg::DEF_MAX_WIDTH * abr_pkg::DEF_MAX_HEIGHT;
    localparam int IDLE_LIMIT  = 300000;

    typedef struct packed
    {
        abr_pkg::kind_t                     kind;
        logic signed [abr_pkg::COORD_W-1:0] px;
        logic signed [abr_pkg::COORD_W-1:0] py;
        logic signed [abr_pkg::COORD_W-1:0] ew;
        logic signed [abr_pkg::COORD_W-1:0] eh;
        logic signed [abr_pkg::COORD_W-1:0] rad;
        logic [abr_pkg::COLOR_W-1:0]        paint;
    } draw_cmd_t;

    typedef struct packed
    {
        logic [abr_pkg::COLOR_W-1:0] color;
        logic [abr_pkg::COUNT_W-1:0] count;
    } draw_res_t;

    class raster_scoreboard;
        logic [abr_pkg::COLOR_W-1:0] frame [FRAME_DEPTH];
        int                          img_w;
        int                          img_h;
        draw_res_t                   pending [$];
        int                          errors;
        int                          n_checked;
        int                          n_kind [4];
        longint                      n_pixels;

        function void reset_state();
            foreach (frame[i])
                frame[i] = '0;
            img_w = abr_pkg::DEF_MAX_WIDTH;
            img_h = abr_pkg::DEF_MAX_HEIGHT;
        endfunction

        function void configure(logic [abr_pkg::CFG_IDX_W-1:0] idx,
                                logic [abr_pkg::CFG_DATA_W-1:0] val);
            if (idx == abr_pkg::REG_IMAGE_WIDTH)
                img_w = int'(val);
            else
                img_h = int'(val);
        endfunction

        function int act_w();
            return (img_w > abr_pkg::DEF_MAX_WIDTH) ? abr_pkg::DEF_MAX_WIDTH : img_w;
        endfunction

        function int act_h();
            return (img_h > abr_pkg::DEF_MAX_HEIGHT) ? abr_pkg::DEF_MAX_HEIGHT : img_h;
        endfunction

        function bit in_image(int x, int y);
            return x >= 0 && y >= 0 && x < act_w() && y < act_h();
        endfunction

        function int unsigned addr(int x, int y);
            return 32'((y * act_w() + x) % FRAME_DEPTH);
        endfunction

        function logic [abr_pkg::COLOR_W-1:0] blend(logic [abr_pkg::COLOR_W-1:0] fg,
                                                    logic [abr_pkg::COLOR_W-1:0] bg);
            int unsigned a;
            logic [abr_pkg::COLOR_W-1:0] mix;
            a = 32'(fg[7:0]);
            if (a == 0)
                return bg;
            if (a == 255)
                return {fg[31:8], abr_pkg::ALPHA_MAX};
            mix = {24'd0, abr_pkg::ALPHA_MAX};
            for (int s = 8; s <= 24; s += 8)
                mix[s +: 8] = 8'((a * 32'(fg[s +: 8]) + (255 - a) * 32'(bg[s +: 8])) / 255);
            return mix;
        endfunction

        function int plot(int x, int y, logic [abr_pkg::COLOR_W-1:0] paint);
            int unsigned i;
            if (!in_image(x, y))
                return 0;
            i = addr(x, y);
            frame[i] = blend(paint, frame[i]);
            return 1;
        endfunction

        function void note(draw_cmd_t c);
            draw_res_t r;
            int x0, y0, x1, y1, px, py, rad, cnt;
            longint rr, dx, dy;
            px = int'(c.px);
            py = int'(c.py);
            rad = int'(c.rad);
            cnt = 0;
            r.color = '0;
            if (c.kind == abr_pkg::KIND_READ) begin
                if (in_image(px, py))
                    r.color = frame[addr(px, py)];
            end
            else if (c.kind == abr_pkg::KIND_PIXEL) begin
                cnt = plot(px, py, c.paint);
            end
            else if (c.kind == abr_pkg::KIND_RECT) begin
                if (c.ew > 0 && c.eh > 0) begin
                    x0 = px < 0 ? 0 : px;
                    y0 = py < 0 ? 0 : py;
                    x1 = px + int'(c.ew);
                    y1 = py + int'(c.eh);
                    if (x1 > act_w()) x1 = act_w();
                    if (y1 > act_h()) y1 = act_h();
                    for (int y = y0; y < y1; y++)
                        for (int x = x0; x < x1; x++)
                            cnt += plot(x, y, c.paint);
                end
            end
            else if (rad > 0) begin
                rr = longint'(rad) * longint'(rad);
                x0 = px - rad;
                x1 = px + rad;
                y0 = py - rad;
                y1 = py + rad;
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > act_w() - 1) x1 = act_w() - 1;
                if (y1 > act_h() - 1) y1 = act_h() - 1;
                for (int y = y0; y <= y1; y++)
                    for (int x = x0; x <= x1; x++) begin
                        dx = longint'(px - x);
                        dy = longint'(py - y);
                        if (dx * dx + dy * dy <= rr)
                            cnt += plot(x, y, c.paint);
                    end
            end
            if (cnt > int'(abr_pkg::COUNT_MAX))
                cnt = int'(abr_pkg::COUNT_MAX);
            r.count = 17'(cnt);
            n_kind[c.kind]++;
            n_pixels += longint'(cnt);
            pending.push_back(r);
        endfunction

        function void check(logic [abr_pkg::COLOR_W-1:0] color,
                            logic [abr_pkg::COUNT_W-1:0] count);
            draw_res_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: read_color %h pixels_touched %0d",
                         $time, color, count);
                errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (color !== e.color) begin
                $display("%0t read_color mismatch: expected %h actual %h", $time, e.color, color);
                errors++;
            end
            if (count !== e.count) begin
                $display("%0t pixels_touched mismatch: expected %0d actual %0d",
                         $time, e.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [1:0]                         kind = '0;
    logic signed [abr_pkg::COORD_W-1:0] pos_x = '0;
    logic signed [abr_pkg::COORD_W-1:0] pos_y = '0;
    logic signed [abr_pkg::COORD_W-1:0] extent_w = '0;
    logic signed [abr_pkg::COORD_W-1:0] extent_h = '0;
    logic signed [abr_pkg::COORD_W-1:0] radius = '0;
    logic [abr_pkg::COLOR_W-1:0]        paint = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [abr_pkg::COLOR_W-1:0]        read_color;
    logic [abr_pkg::COUNT_W-1:0]        pixels_touched;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [abr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [abr_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    raster_scoreboard sb;
    int  idle_cycles;
    bit  sender_steady;
    bit  sink_steady;
    bit  stall_done;

    always #1 clk = ~clk;

    alpha_blend_shape_rasterizer u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .extent_w       (extent_w),
        .extent_h       (extent_h),
        .radius         (radius),
        .paint          (paint),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_color     (read_color),
        .pixels_touched (pixels_touched),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(5, 40));
    endfunction

    task automatic send_cmd(draw_cmd_t c);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= c.kind;
        pos_x    <= c.px;
        pos_y    <= c.py;
        extent_w <= c.ew;
        extent_h <= c.eh;
        radius   <= c.rad;
        paint    <= c.paint;
        do @(posedge clk); while (!in_ready);
        sb.note(c);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [abr_pkg::CFG_IDX_W-1:0] idx,
                             logic [abr_pkg::CFG_DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.configure(idx, val);
    endtask

    function automatic draw_cmd_t mk(abr_pkg::kind_t k, int x, int y, int w, int h, int r,
                                     logic [abr_pkg::COLOR_W-1:0] p);
        draw_cmd_t c;
        c.kind  = k;
        c.px    = 16'(x);
        c.py    = 16'(y);
        c.ew    = 16'(w);
        c.eh    = 16'(h);
        c.rad   = 16'(r);
        c.paint = p;
        return c;
    endfunction

    function automatic logic [abr_pkg::COLOR_W-1:0] rand_paint();
        logic [abr_pkg::COLOR_W-1:0] p;
        int r;
        p = $urandom;
        r = int'($urandom_range(0, 9));
        if (r < 2)
            p[7:0] = 8'h00;
        else if (r < 4)
            p[7:0] = abr_pkg::ALPHA_MAX;
        return p;
    endfunction

    // full-range extents only when the image is small enough to stay cheap
    function automatic draw_cmd_t rand_cmd();
        draw_cmd_t c;
        int  span_x, span_y, cap;
        bit  cheap;
        span_x = sb.act_w();
        span_y = sb.act_h();
        cheap  = (span_x * span_y <= 4096);
        cap    = cheap ? 40 : 24;
        c.kind = abr_pkg::kind_t'($urandom_range(0, 3));
        c.px   = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                             : 16'(int'($urandom_range(0, span_x + 40)) - 20);
        c.py   = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                             : 16'(int'($urandom_range(0, span_y + 40)) - 20);
        if (cheap && $urandom_range(0, 6) == 0) begin
            c.ew  = 16'($urandom);
            c.eh  = 16'($urandom);
            c.rad = 16'($urandom);
        end
        else begin
            c.ew  = 16'(int'($urandom_range(0, cap)) - 2);
            c.eh  = 16'(int'($urandom_range(0, cap)) - 2);
            c.rad = 16'(int'($urandom_range(0, cap / 2)) - 1);
        end
        c.paint = rand_paint();
        return c;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            send_cmd(rand_cmd());
        end
    endtask

    // result side
    initial begin
        int hold;
        @(posedge rst_n);
        forever begin
            if (!stall_done && sb.n_checked >= 200) begin
                stall_done = 1'b1;
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            if (sb.n_checked % 50 == 0)
                sink_steady = ($urandom_range(0, 3) == 0);
            hold = sink_steady ? 0 : pick_gap();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid)
                sb.check(read_color, pixels_touched);
        end
    end

    // watchdog
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog expired, %0d results outstanding",
                         $time, sb.pending.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        sb.reset_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        sender_steady = 1'b0;
        send_cmd(mk(abr_pkg::KIND_READ, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(mk(abr_pkg::KIND_READ, 255, 255, -1, -1, -1, '0));
        send_cmd(mk(abr_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 32'h1234_56FF));
        send_cmd(mk(abr_pkg::KIND_PIXEL, 255, 255, 0, 0, 0, 32'hABCD_EF00));
        send_cmd(mk(abr_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 32'hFF00_8080));
        send_cmd(mk(abr_pkg::KIND_READ, 0, 0, 0, 0, 0, '0));
        send_cmd(mk(abr_pkg::KIND_READ, 255, 255, 0, 0, 0, '0));
        send_cmd(mk(abr_pkg::KIND_PIXEL, -1, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(mk(abr_pkg::KIND_PIXEL, 256, 3, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(mk(abr_pkg::KIND_READ, 32767, -32768, 32767, -32768, 32767, 32'hFFFF_FFFF));
        send_cmd(mk(abr_pkg::KIND_RECT, 5, 5, 0, 10, 0, 32'h1111_11FF));
        send_cmd(mk(abr_pkg::KIND_RECT, 5, 5, 10, -5, 0, 32'h1111_11FF));
        send_cmd(mk(abr_pkg::KIND_RECT, -32768, -32768, 32767, 32767, 0, 32'h2222_22FF));
        send_cmd(mk(abr_pkg::KIND_RECT, 0, 0, 256, 256, 0, 32'h4080_C0FF));
        send_cmd(mk(abr_pkg::KIND_RECT, -3, -3, 10, 10, 0, 32'hFF00_0040));
        send_cmd(mk(abr_pkg::KIND_RECT, 200, 200, 32767, 32767, 0, 32'h00FF_00C0));
        send_cmd(mk(abr_pkg::KIND_DISC, 50, 50, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(mk(abr_pkg::KIND_DISC, 50, 50, 0, 0, -32768, 32'hFFFF_FFFF));
        send_cmd(mk(abr_pkg::KIND_DISC, 0, 0, 0, 0, 5, 32'h0000_FF7F));
        send_cmd(mk(abr_pkg::KIND_DISC, 100, 100, 0, 0, 3, 32'hC0C0_C064));
        send_cmd(mk(abr_pkg::KIND_DISC, 100, 100, 0, 0, 1, 32'h0000_0000));
        send_cmd(mk(abr_pkg::KIND_READ, 100, 100, 0, 0, 0, '0));
        send_cmd(mk(abr_pkg::KIND_READ, 1, 1, 0, 0, 0, '0));

        random_phase(140);

        write_reg(abr_pkg::REG_IMAGE_WIDTH, 9'd37);
        write_reg(abr_pkg::REG_IMAGE_HEIGHT, 9'd19);
        send_cmd(mk(abr_pkg::KIND_DISC, 18, 9, 0, 0, 32767, 32'h5555_55AA));
        random_phase(120);

        write_reg(abr_pkg::REG_IMAGE_WIDTH, 9'd0);
        write_reg(abr_pkg::REG_IMAGE_HEIGHT, 9'd300);
        random_phase(40);

        write_reg(abr_pkg::REG_IMAGE_WIDTH, 9'd1);
        write_reg(abr_pkg::REG_IMAGE_HEIGHT, 9'd1);
        random_phase(40);

        write_reg(abr_pkg::REG_IMAGE_WIDTH, 9'd511);
        write_reg(abr_pkg::REG_IMAGE_HEIGHT, 9'd511);
        random_phase(120);

        write_reg(abr_pkg::REG_IMAGE_WIDTH, 9'd64);
        write_reg(abr_pkg::REG_IMAGE_HEIGHT, 9'd48);
        random_phase(100);

        drain();
        $display("covered %0d reads, %0d pixels, %0d rectangles, %0d discs",
                 sb.n_kind[abr_pkg::KIND_READ], sb.n_kind[abr_pkg::KIND_PIXEL],
                 sb.n_kind[abr_pkg::KIND_RECT], sb.n_kind[abr_pkg::KIND_DISC]);
        $display("%0d results checked, %0d pixels blended, 6 image sizes",
                 sb.n_checked, sb.n_pixels);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
